### hw/rtl/fsub_pkg.sv
// shared constants and types for the first substring match block
package fsub_pkg;

	localparam int MAX_PATTERN = 16;
	localparam int MAX_TEXT    = 4096;

	localparam int CHAR_W = 8;
	localparam int OFF_W  = 12;
	localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
	localparam int POS_W  = $clog2(MAX_TEXT + 1);

	localparam logic OP_PATTERN = 1'b0;
	localparam logic OP_TEXT    = 1'b1;

	// controls common to every cell of the chain
	typedef struct packed {
		logic step;
		logic clr;
	} fsub_ctrl_t;

endpackage

### hw/rtl/fsub_cell.sv
// one cell of the match chain: a pattern byte and its partial match bit
module fsub_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  fsub_pkg::fsub_ctrl_t     ctrl,
	input  logic                     wr_en,
	input  logic                     active,
	input  logic                     tail,
	input  logic [fsub_pkg::CHAR_W-1:0] char_code,
	input  logic                     prev_hit,
	output logic                     hit,
	output logic                     tail_hit
);
	import fsub_pkg::*;

	logic [CHAR_W-1:0] store_q;
	logic              hit_q;
	logic              hit_next;

	// pattern byte held by this cell
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q <= char_code;
		end
	end

	// partial match: neighbor matched up to here and this byte agrees
	assign hit_next = prev_hit && active && (store_q == char_code);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctrl.clr) begin
			hit_q <= 1'b0;
		end else if (ctrl.step) begin
			hit_q <= hit_next;
		end
	end

	assign hit      = hit_q;
	assign tail_hit = hit_next && tail;

endmodule

### hw/rtl/first_substring_match.sv
// top level: pattern loader, text counter, cell chain and result register
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid, in_ready, op, char_code, last        | input item
//  out     | out_valid, out_ready, found, match_offset,     | result item
//          | pattern_error, text_overflow                   |
//
// one item per cycle while in_ready is high: on each stepped text item every cell compares its
// byte with the text byte and takes its neighbor's match bit in the same cycle the item is accepted.
// a result appears in the output register the cycle after the final text item.
// in_ready drops only while a result waits and out_ready is low.
// arst_n clears control state and match bits; pattern bytes need a reload.
module first_substring_match (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          op,
	input  logic [fsub_pkg::CHAR_W-1:0]   char_code,
	input  logic                          last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          found,
	output logic [fsub_pkg::OFF_W-1:0]    match_offset,
	output logic                          pattern_error,
	output logic                          text_overflow
);
	import fsub_pkg::*;

	logic [LEN_W-1:0] len_q;
	logic             ovf_q;
	logic             done_q;
	logic [POS_W-1:0] pos_q;
	logic             seen_q;
	logic [OFF_W-1:0] first_q;
	logic             sat_q;
	logic             out_valid_q;
	logic             found_q;
	logic [OFF_W-1:0] offset_q;
	logic             perr_q;
	logic             tovf_q;

	logic             acc;
	logic             pat_acc;
	logic             txt_acc;
	logic             perr;
	logic             at_limit;
	logic             room;
	logic [LEN_W-1:0] wr_idx;
	logic             new_match;
	logic [OFF_W-1:0] cand_off;
	logic             clr_text;
	fsub_ctrl_t       ctrl;

	logic [MAX_PATTERN-1:0] hits;
	logic [MAX_PATTERN-1:0] tail_hits;
	logic [MAX_PATTERN:0]   chain;

	// handshake
	assign in_ready = !out_valid_q || out_ready;
	assign acc      = in_valid && in_ready;
	assign pat_acc  = acc && (op == OP_PATTERN);
	assign txt_acc  = acc && (op == OP_TEXT);

	// job status
	assign perr     = (len_q == '0) || ovf_q;
	assign at_limit = (pos_q >= POS_W'(MAX_TEXT));
	assign room     = done_q || (len_q < LEN_W'(MAX_PATTERN));
	assign wr_idx   = done_q ? '0 : len_q;
	assign clr_text = (pat_acc && done_q) || (txt_acc && last);

	assign ctrl.step = txt_acc && !at_limit && !perr;
	assign ctrl.clr  = clr_text;

	// chain of cells, the partial match bit moves one cell per text item
	assign chain[0] = 1'b1;

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		fsub_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.wr_en     (pat_acc && room && (wr_idx == LEN_W'(i))),
			.active    (LEN_W'(i) < len_q),
			.tail      (LEN_W'(i + 1) == len_q),
			.char_code (char_code),
			.prev_hit  (chain[i]),
			.hit       (hits[i]),
			.tail_hit  (tail_hits[i])
		);
		assign chain[i+1] = hits[i];
	end

	// first full match and its start offset
	assign new_match = ctrl.step && !seen_q && (|tail_hits);
	assign cand_off  = OFF_W'(pos_q) - OFF_W'(len_q) + OFF_W'(1);

	// pattern state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			ovf_q  <= 1'b0;
			done_q <= 1'b0;
		end else if (pat_acc) begin
			if (done_q) begin
				len_q  <= LEN_W'(1);
				ovf_q  <= 1'b0;
				done_q <= last;
			end else begin
				if (len_q < LEN_W'(MAX_PATTERN)) begin
					len_q <= len_q + LEN_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
				done_q <= last;
			end
		end else if (txt_acc) begin
			done_q <= 1'b1;
		end
	end

	// text state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			seen_q  <= 1'b0;
			first_q <= '0;
			sat_q   <= 1'b0;
		end else if (clr_text) begin
			pos_q   <= '0;
			seen_q  <= 1'b0;
			first_q <= '0;
			sat_q   <= 1'b0;
		end else if (txt_acc) begin
			if (at_limit) begin
				sat_q <= 1'b1;
			end else begin
				pos_q <= pos_q + POS_W'(1);
			end
			if (new_match) begin
				seen_q  <= 1'b1;
				first_q <= cand_off;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (txt_acc && last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (txt_acc && last) begin
			found_q  <= (seen_q || new_match) && !perr;
			offset_q <= perr ? '0 : (seen_q ? first_q : (new_match ? cand_off : '0));
			perr_q   <= perr;
			tovf_q   <= sat_q || at_limit;
		end
	end

	assign out_valid     = out_valid_q;
	assign found         = found_q;
	assign match_offset  = offset_q;
	assign pattern_error = perr_q;
	assign text_overflow = tovf_q;

endmodule
